/* rtl/pas_pkg.sv */
// ----------------------------------------------------------------------------
// pas_pkg
// Shared types, codes and helpers for the pneumatic actuator sequencer.
// ----------------------------------------------------------------------------
package pas_pkg;

  localparam int MAX_CUPS_DEFAULT = 8;

  localparam int CUP_W   = 3;
  localparam int LIMIT_W = 16;
  localparam int COUNT_W = 16;
  localparam int FLAGS_W = 3;
  localparam int CODE_W  = 3;
  localparam int CFG_W   = 4;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;

  // Cups that a cup index can name.
  localparam int CUP_SLOTS = 2 ** CUP_W;

  localparam logic [CFG_W-1:0] INSTALLED_RESET = 4'd1;

  // Register index, taken from the word address.
  localparam logic [0:0] REG_CUP_COUNT = 1'b0;

  // Error flag bits.
  localparam int FLAG_SWITCH      = 0;
  localparam int FLAG_INS_TIMEOUT = 1;
  localparam int FLAG_WDR_TIMEOUT = 2;

  // Reported state codes.
  localparam logic [CODE_W-1:0] CODE_BOOTED      = 3'd0;
  localparam logic [CODE_W-1:0] CODE_EXTRACTED   = 3'd1;
  localparam logic [CODE_W-1:0] CODE_INSERTING   = 3'd2;
  localparam logic [CODE_W-1:0] CODE_INSERTED    = 3'd3;
  localparam logic [CODE_W-1:0] CODE_WITHDRAWING = 3'd4;
  localparam logic [CODE_W-1:0] CODE_ERROR       = 3'd5;

  typedef enum logic [5:0] {
    ST_BOOTED      = 6'b000001,
    ST_EXTRACTED   = 6'b000010,
    ST_INSERTING   = 6'b000100,
    ST_INSERTED    = 6'b001000,
    ST_WITHDRAWING = 6'b010000,
    ST_ERROR       = 6'b100000
  } cup_state_t;

  typedef struct packed {
    logic [CUP_W-1:0]   cup_index;
    logic               request_insert;
    logic               switch_closed;
    logic [LIMIT_W-1:0] insert_limit;
    logic [LIMIT_W-1:0] withdraw_limit;
  } in_item_t;

  typedef struct packed {
    logic               actuator_drive;
    logic               command_pulse;
    logic [FLAGS_W-1:0] error_flags;
    logic [CODE_W-1:0]  cup_state_now;
  } out_item_t;

  function automatic logic [CODE_W-1:0] state_code(input cup_state_t st);
    logic [CODE_W-1:0] code;
    unique case (st)
      ST_BOOTED:      code = CODE_BOOTED;
      ST_EXTRACTED:   code = CODE_EXTRACTED;
      ST_INSERTING:   code = CODE_INSERTING;
      ST_INSERTED:    code = CODE_INSERTED;
      ST_WITHDRAWING: code = CODE_WITHDRAWING;
      default:        code = CODE_ERROR;
    endcase
    return code;
  endfunction

endpackage

/* rtl/pas_if.sv */
// ----------------------------------------------------------------------------
// pas_if
// Valid/ready channels for cup ticks and for sequencer results.
// ----------------------------------------------------------------------------
interface pas_in_if;
  logic                        valid;
  logic                        ready;
  logic [pas_pkg::CUP_W-1:0]   cup_index;
  logic                        request_insert;
  logic                        switch_closed;
  logic [pas_pkg::LIMIT_W-1:0] insert_limit;
  logic [pas_pkg::LIMIT_W-1:0] withdraw_limit;

  modport source (output valid, cup_index, request_insert, switch_closed,
                  insert_limit, withdraw_limit, input ready);
  modport sink   (input valid, cup_index, request_insert, switch_closed,
                  insert_limit, withdraw_limit, output ready);
endinterface

interface pas_out_if;
  logic                        valid;
  logic                        ready;
  logic                        actuator_drive;
  logic                        command_pulse;
  logic [pas_pkg::FLAGS_W-1:0] error_flags;
  logic [pas_pkg::CODE_W-1:0]  cup_state_now;

  modport source (output valid, actuator_drive, command_pulse, error_flags,
                  cup_state_now, input ready);
  modport sink   (input valid, actuator_drive, command_pulse, error_flags,
                  cup_state_now, output ready);
endinterface

/* rtl/pneumatic_actuator_sequencer_core.sv */
// ----------------------------------------------------------------------------
// pneumatic_actuator_sequencer_core
// Per-cup insert/withdraw sequencer with end-switch checks and move timeouts.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake          | carries
//  ----------+-----+--------------------+------------------------------------
//  in_ch     | in  | valid/ready        | cup index, request, switch, limits
//  out_ch    | out | valid/ready        | drive, pulse, error flags, state
//  apb       | in  | psel/penable/pready| cup_count at byte address 0
//
//  One transaction per cycle sustained while out_ch is ready; each tick passes
//  through the input register, then the result register.
//  The cup state and counter file is updated as a tick leaves the input
//  register, so the next tick for the same cup sees the new state directly.
//  rst is synchronous: all cups return to booted with zero counts and
//  cup_count returns to 1.
//  A stall on out_ch holds the result register and backs up through the
//  input register; in_ch.ready drops only when both registers are full.
// ----------------------------------------------------------------------------
module pneumatic_actuator_sequencer_core #(
  parameter int MAX_CUPS = pas_pkg::MAX_CUPS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  pas_in_if.sink                     in_ch,
  pas_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pas_pkg::ADDR_W-1:0] paddr,
  input  logic [pas_pkg::DATA_W-1:0] pwdata,
  output logic [pas_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  logic [pas_pkg::CFG_W-1:0] cup_count;

  // Input register.
  logic                s1_valid;
  pas_pkg::in_item_t   s1_item;
  logic                s1_adv;

  // Result register.
  logic                out_valid;
  pas_pkg::out_item_t  out_item;
  pas_pkg::out_item_t  step_result;

  pas_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cup_count (cup_count)
  );

  // Advance the input register whenever the result register can take it.
  assign s1_adv      = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item.cup_index      <= in_ch.cup_index;
      s1_item.request_insert <= in_ch.request_insert;
      s1_item.switch_closed  <= in_ch.switch_closed;
      s1_item.insert_limit   <= in_ch.insert_limit;
      s1_item.withdraw_limit <= in_ch.withdraw_limit;
    end
  end

  pas_cup #(
    .MAX_CUPS (MAX_CUPS)
  ) u_cup (
    .clk       (clk),
    .rst       (rst),
    .step_en   (s1_adv),
    .item      (s1_item),
    .cup_count (cup_count),
    .result    (step_result)
  );

  // Hold the result until the sink takes it; load a fresh one on advance.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_item <= step_result;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.actuator_drive = out_item.actuator_drive;
  assign out_ch.command_pulse  = out_item.command_pulse;
  assign out_ch.error_flags    = out_item.error_flags;
  assign out_ch.cup_state_now  = out_item.cup_state_now;

`ifndef NO_ASSERTIONS
  // A command pulse only starts a move.
  a_pulse_starts_move: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.command_pulse |->
      (out_item.cup_state_now == pas_pkg::CODE_INSERTING) ||
      (out_item.cup_state_now == pas_pkg::CODE_WITHDRAWING))
    else $error("command pulse without a move start");

  // Drive is zero whenever there is no pulse.
  a_drive_needs_pulse: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.command_pulse |-> !out_item.actuator_drive)
    else $error("actuator drive set without a pulse");

  // An insert timeout is only reported while inserting.
  a_ins_timeout_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.error_flags[pas_pkg::FLAG_INS_TIMEOUT] |->
      (out_item.cup_state_now == pas_pkg::CODE_INSERTING))
    else $error("insert timeout outside of inserting");

  // A tick stalled in the input register stays there.
  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_item))
    else $error("stalled tick lost from input register");
`endif

endmodule

/* rtl/pas_cfg.sv */
// ----------------------------------------------------------------------------
// pas_cfg
// APB register block holding the installed cup count.
// ----------------------------------------------------------------------------
module pas_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pas_pkg::ADDR_W-1:0]  paddr,
  input  logic [pas_pkg::DATA_W-1:0]  pwdata,
  output logic [pas_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output logic [pas_pkg::CFG_W-1:0]   cup_count
);

  logic [0:0] reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cup_count <= pas_pkg::INSTALLED_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (reg_index == pas_pkg::REG_CUP_COUNT)) begin
      cup_count <= pwdata[pas_pkg::CFG_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_index)
      pas_pkg::REG_CUP_COUNT:
        prdata = {{(pas_pkg::DATA_W-pas_pkg::CFG_W){1'b0}}, cup_count};
      default:
        prdata = '0;
    endcase
  end

endmodule

/* rtl/pas_cup.sv */
// ----------------------------------------------------------------------------
// pas_cup
// Per-cup state and counter file with the one-tick sequencer update.
// ----------------------------------------------------------------------------
module pas_cup #(
  parameter int MAX_CUPS = pas_pkg::MAX_CUPS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step_en,
  input  pas_pkg::in_item_t         item,
  input  logic [pas_pkg::CFG_W-1:0] cup_count,
  output pas_pkg::out_item_t        result
);

  localparam int DEPTH = (MAX_CUPS < pas_pkg::CUP_SLOTS) ? MAX_CUPS : pas_pkg::CUP_SLOTS;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SLOTS = 2 ** IDX_W;

  pas_pkg::cup_state_t               st_mem  [SLOTS];
  logic [pas_pkg::COUNT_W-1:0]       cnt_mem [SLOTS];

  logic [IDX_W-1:0]                  idx;
  logic                              active;
  pas_pkg::cup_state_t               cur;
  pas_pkg::cup_state_t               nxt;
  logic [pas_pkg::COUNT_W-1:0]       cnt;
  logic [pas_pkg::COUNT_W-1:0]       cnt_inc;
  logic [pas_pkg::COUNT_W-1:0]       cnt_next;
  logic [pas_pkg::LIMIT_W-1:0]       lim;
  logic [pas_pkg::LIMIT_W-1:0]       lim_eff;
  logic                              moving;
  logic                              timeout;
  logic                              pulse;
  logic                              drive;
  logic [pas_pkg::FLAGS_W-1:0]       flags;

  assign idx = item.cup_index[IDX_W-1:0];

  // Cup zero is always in use; others need both the register and the build.
  assign active = (item.cup_index == '0) ||
                  ((32'(item.cup_index) < 32'(cup_count)) &&
                   (32'(item.cup_index) < MAX_CUPS));

  always_comb begin
    cur   = st_mem[idx];
    cnt   = cnt_mem[idx];
    nxt   = cur;
    pulse = 1'b0;
    drive = 1'b0;
    flags = '0;
    unique case (cur)
      pas_pkg::ST_BOOTED: begin
        if (item.request_insert && item.switch_closed) begin
          nxt = pas_pkg::ST_INSERTED;
        end else begin
          nxt = pas_pkg::ST_ERROR;
          flags[pas_pkg::FLAG_SWITCH] = 1'b1;
        end
      end
      pas_pkg::ST_EXTRACTED: begin
        if (item.switch_closed) begin
          nxt = pas_pkg::ST_ERROR;
          flags[pas_pkg::FLAG_SWITCH] = 1'b1;
        end else if (item.request_insert) begin
          nxt   = pas_pkg::ST_INSERTING;
          pulse = 1'b1;
          drive = 1'b1;
        end
      end
      pas_pkg::ST_INSERTING: begin
        if (item.switch_closed) begin
          nxt = pas_pkg::ST_INSERTED;
        end
      end
      pas_pkg::ST_INSERTED: begin
        if (!item.switch_closed) begin
          nxt = pas_pkg::ST_ERROR;
          flags[pas_pkg::FLAG_SWITCH] = 1'b1;
        end else if (!item.request_insert) begin
          nxt   = pas_pkg::ST_WITHDRAWING;
          pulse = 1'b1;
        end
      end
      pas_pkg::ST_WITHDRAWING: begin
        if (!item.switch_closed) begin
          nxt = pas_pkg::ST_EXTRACTED;
        end
      end
      default: begin
        flags[pas_pkg::FLAG_SWITCH] = 1'b1;
      end
    endcase

    // Run the saturating counter during a move; clear it otherwise.
    moving   = (nxt == pas_pkg::ST_INSERTING) || (nxt == pas_pkg::ST_WITHDRAWING);
    cnt_inc  = (cnt == '1) ? cnt : cnt + 1'b1;
    lim      = (nxt == pas_pkg::ST_INSERTING) ? item.insert_limit : item.withdraw_limit;
    lim_eff  = (lim == '0) ? {{(pas_pkg::LIMIT_W-1){1'b0}}, 1'b1} : lim;
    timeout  = moving && (cnt_inc > lim_eff);
    cnt_next = moving ? cnt_inc : '0;
    if (timeout) begin
      if (nxt == pas_pkg::ST_INSERTING) begin
        flags[pas_pkg::FLAG_INS_TIMEOUT] = 1'b1;
      end else begin
        flags[pas_pkg::FLAG_WDR_TIMEOUT] = 1'b1;
      end
    end

    if (active) begin
      result.actuator_drive = pulse & drive;
      result.command_pulse  = pulse;
      result.error_flags    = flags;
      result.cup_state_now  = pas_pkg::state_code(nxt);
    end else begin
      result = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        st_mem[i]  <= pas_pkg::ST_BOOTED;
        cnt_mem[i] <= '0;
      end
    end else if (step_en && active) begin
      st_mem[idx]  <= nxt;
      cnt_mem[idx] <= cnt_next;
    end
  end

endmodule
